// ===== src/top_n_score_insert_defines.svh =====
// ---------------------------------------------------------------------------
// top_n_score_insert_defines
// assertion macros used by the top n score table module
// ---------------------------------------------------------------------------
`ifndef TOP_N_SCORE_INSERT_DEFINES_SVH
`define TOP_N_SCORE_INSERT_DEFINES_SVH

// property checked at every rising clock edge outside reset
`define TNSI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent checked on the clock after the antecedent
`define TNSI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tnsi_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tnsi_pkg
// types and constants of the top n score table
// ---------------------------------------------------------------------------
package tnsi_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int SCORE_W     = 32;
	localparam int ID_W        = 32;
	localparam int INDEX_W     = 4;
	localparam int POS_W       = 4;

	// 68 bits of fields, padded to 72
	localparam int IN_DATA_W  = 72;
	// 69 bits of fields, padded to 72
	localparam int OUT_DATA_W = 72;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_READ   = 1'b1;

	localparam logic signed [SCORE_W-1:0] SCORE_EMPTY = {1'b1, {(SCORE_W-1){1'b0}}};

	// what one slot hands to the next one down
	typedef struct packed {
		logic                        ge;
		logic signed [SCORE_W-1:0]   score;
		logic        [ID_W-1:0]      id;
	} link_t;

	localparam link_t LINK_HEAD = '{ge: 1'b0, score: SCORE_EMPTY, id: '0};

endpackage

// ===== src/top_n_score_insert.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// top_n_score_insert
// keeps the best (score, id) pairs in descending score order
// ---------------------------------------------------------------------------
// Each slot is a compare-and-shift cell: on an insert every cell compares the
// new score with its own and either keeps, loads the new pair or takes its
// upper neighbor's pair, all cells updating together. A read selects the slot
// at the given index. One item is taken per clock while results are being
// taken; the result shows in the cycle after the item is accepted, from a
// single output register, and the next item already sees the updated table.
`include "top_n_score_insert_defines.svh"

module top_n_score_insert (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// score[31:0], item_id[63:32], index[67:64], zero pad
	input  logic [tnsi_pkg::IN_DATA_W-1:0]      s_tdata,
	// mode
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// accepted[0], position[4:1], read_score[36:5], read_id[68:37], zero pad
	output logic [tnsi_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import tnsi_pkg::*;

	logic                      take;
	logic                      ins;
	logic signed [SCORE_W-1:0] in_score;
	logic        [ID_W-1:0]    in_id;
	logic        [INDEX_W-1:0] in_index;
	link_t                     lnk [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]    ge_vec;

	logic                      hit;
	logic        [POS_W-1:0]   pos;
	logic signed [SCORE_W-1:0] rd_score;
	logic        [ID_W-1:0]    rd_id;

	logic                      out_valid_q;
	logic                      acc_q;
	logic        [POS_W-1:0]   pos_q;
	logic signed [SCORE_W-1:0] rd_score_q;
	logic        [ID_W-1:0]    rd_id_q;

	assign in_score = s_tdata[SCORE_W-1:0];
	assign in_id    = s_tdata[SCORE_W+ID_W-1:SCORE_W];
	assign in_index = s_tdata[SCORE_W+ID_W+INDEX_W-1:SCORE_W+ID_W];

	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;
	assign ins      = take && (s_tuser == MODE_INSERT);

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_slot
		if (k == 0) begin : g_head
			tnsi_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ins       (ins),
				.new_score (in_score),
				.new_id    (in_id),
				.prev      (LINK_HEAD),
				.cur       (lnk[k])
			);
		end else begin : g_body
			tnsi_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ins       (ins),
				.new_score (in_score),
				.new_id    (in_id),
				.prev      (lnk[k-1]),
				.cur       (lnk[k])
			);
		end
		assign ge_vec[k] = lnk[k].ge;
	end

	// table stays sorted, so the compare flags form a thermometer code
	always_comb begin
		hit = ge_vec[TABLE_DEPTH-1];
		pos = '0;
		for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
			if (ge_vec[k]) begin
				pos = POS_W'(k);
			end
		end
	end

	// out of range index reads as zero
	always_comb begin
		rd_score = '0;
		rd_id    = '0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			if (int'(in_index) == k) begin
				rd_score = lnk[k].score;
				rd_id    = lnk[k].id;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (s_tuser == MODE_READ) begin
				acc_q      <= 1'b0;
				pos_q      <= '0;
				rd_score_q <= rd_score;
				rd_id_q    <= rd_id;
			end else begin
				acc_q      <= hit;
				pos_q      <= hit ? pos : '0;
				rd_score_q <= '0;
				rd_id_q    <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-1-POS_W-SCORE_W-ID_W){1'b0}},
		rd_id_q, rd_score_q, pos_q, acc_q};

	`TNSI_ASSERT(a_ge_thermo, $onehot0(ge_vec ^ (ge_vec << 1)), "compare flags not monotonic")
	`TNSI_ASSERT(a_acc_no_read, !(out_valid_q && acc_q) || (rd_score_q == '0 && rd_id_q == '0),
		"accepted insert result carries read data")
	`TNSI_ASSERT_NEXT(a_read_keeps_head, take && (s_tuser == MODE_READ),
		$stable(lnk[0].score) && $stable(lnk[TABLE_DEPTH-1].score), "read changed the table")
	`TNSI_ASSERT_NEXT(a_reject_keeps, ins && !hit, $stable(lnk[0].score) && $stable(lnk[0].id),
		"rejected insert changed the table")

endmodule

// ===== src/tnsi_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tnsi_cell
// one slot of the table: compares the new score and shifts or loads
// ---------------------------------------------------------------------------
module tnsi_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              ins,
	input  logic signed [tnsi_pkg::SCORE_W-1:0] new_score,
	input  logic        [tnsi_pkg::ID_W-1:0]    new_id,
	input  tnsi_pkg::link_t                   prev,
	output tnsi_pkg::link_t                   cur
);
	import tnsi_pkg::*;

	logic signed [SCORE_W-1:0] score_q;
	logic        [ID_W-1:0]    id_q;
	logic                      ge;

	// stored score not greater than the new one
	assign ge = (new_score >= score_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= SCORE_EMPTY;
			id_q    <= '0;
		end else if (ins) begin
			if (prev.ge) begin
				// insertion point is above: take the neighbor's entry
				score_q <= prev.score;
				id_q    <= prev.id;
			end else if (ge) begin
				score_q <= new_score;
				id_q    <= new_id;
			end
		end
	end

	assign cur.ge    = ge;
	assign cur.score = score_q;
	assign cur.id    = id_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// checks the top n score table against a cycle-free model of its slots
// ---------------------------------------------------------------------------
// Items go in through the slave stream and results come back one per item.
// A small score table model in the board class ranks every accepted item and
// queues the result it should give; each result taken from the master stream
// is compared field by field with the oldest one queued. A directed part
// covers empty slots, extremes, equal scores and rejection; random inserts
// and reads follow under three idling patterns and one long output stall.
module testbench;
	import tnsi_pkg::*;

	typedef struct packed {
		logic                      accepted;
		logic [POS_W-1:0]          position;
		logic signed [SCORE_W-1:0] read_score;
		logic [ID_W-1:0]           read_id;
	} slot_result_t;

	class rank_board;
		logic signed [SCORE_W-1:0] scores [TABLE_DEPTH];
		logic [ID_W-1:0]           ids [TABLE_DEPTH];
		slot_result_t              pending_results [$];
		int                        errors;

		function new();
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				scores[k] = SCORE_EMPTY;
				ids[k] = '0;
			end
			errors = 0;
		endfunction

		// update the table with one accepted item and queue its result
		function void rank_item(logic mode, logic signed [SCORE_W-1:0] score,
				logic [ID_W-1:0] id, logic [INDEX_W-1:0] index);
			slot_result_t r;
			int pos;
			r = '0;
			if (mode == MODE_READ) begin
				if (index < TABLE_DEPTH) begin
					r.read_score = scores[index];
					r.read_id = ids[index];
				end
			end else begin
				pos = TABLE_DEPTH;
				for (int k = 0; k < TABLE_DEPTH; k++) begin
					if (scores[k] <= score) begin
						pos = k;
						break;
					end
				end
				if (pos < TABLE_DEPTH) begin
					for (int k = TABLE_DEPTH - 1; k > pos; k--) begin
						scores[k] = scores[k-1];
						ids[k] = ids[k-1];
					end
					scores[pos] = score;
					ids[pos] = id;
					r.accepted = 1'b1;
					r.position = pos[POS_W-1:0];
				end
			end
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data);
			slot_result_t want;
			slot_result_t got;
			got.accepted = data[0];
			got.position = data[4:1];
			got.read_score = data[36:5];
			got.read_id = data[68:37];
			if (pending_results.size() == 0) begin
				$error("result with no item waiting: %h", data);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.accepted !== want.accepted) begin
				$error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
				errors++;
			end
			if (got.position !== want.position) begin
				$error("position: expected %0d, got %0d", want.position, got.position);
				errors++;
			end
			if (got.read_score !== want.read_score) begin
				$error("read_score: expected %0d, got %0d", want.read_score, got.read_score);
				errors++;
			end
			if (got.read_id !== want.read_id) begin
				$error("read_id: expected %h, got %h", want.read_id, got.read_id);
				errors++;
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = MODE_INSERT;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	rank_board board = new();
	int        send_idle_pct = 8;
	int        recv_idle_pct = 75;
	bit        hold_req = 1'b0;
	int        hold_left = 0;

	top_n_score_insert dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("testbench failed");
		$finish;
	end

	task automatic send_item(input logic mode, input logic signed [SCORE_W-1:0] score,
			input logic [ID_W-1:0] id, input logic [INDEX_W-1:0] index);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {4'b0, index, id, score};
		do @(posedge clk); while (!s_tready);
		board.rank_item(mode, score, id, index);
	endtask

	function automatic logic signed [SCORE_W-1:0] pick_score();
		logic signed [SCORE_W-1:0] s;
		case ($urandom_range(4))
			0: s = $urandom;
			1: case ($urandom_range(3))
				0: s = 32'sh7FFF_FFFF;
				1: s = SCORE_EMPTY;
				2: s = 0;
				default: s = -1;
			endcase
			// close to a stored score so equal and neighboring values come up
			2: s = board.scores[$urandom_range(TABLE_DEPTH - 1)] + $urandom_range(2) - 1;
			3: s = $signed($urandom_range(1000)) - 500;
			default: s = 32'sh7FFF_FF00 + $urandom_range(255);
		endcase
		return s;
	endfunction

	// output side: takes results and stalls at random or for a long hold
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_result(m_tdata);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 150;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, then extremes and equal scores
		send_item(MODE_READ, 0, 0, 4'd0);
		send_item(MODE_READ, 0, 32'hFFFF_FFFF, 4'd15);
		send_item(MODE_INSERT, SCORE_EMPTY, 32'hFFFF_FFFF, 4'd0);
		send_item(MODE_INSERT, 32'sh7FFF_FFFF, 32'h0, 4'd15);
		send_item(MODE_INSERT, 32'sh7FFF_FFFF, 32'h1234_5678, 4'd0);
		send_item(MODE_INSERT, -1, 32'hA5A5_A5A5, 4'd5);
		send_item(MODE_INSERT, 0, 32'h5A5A_5A5A, 4'd10);
		send_item(MODE_READ, SCORE_EMPTY, 0, 4'd0);
		send_item(MODE_READ, -1, 0, 4'd1);
		send_item(MODE_READ, 0, 0, 4'd4);
		// fill every slot
		for (int k = 0; k < 11; k++)
			send_item(MODE_INSERT, 1000 - k, $urandom, 4'd0);
		send_item(MODE_INSERT, SCORE_EMPTY, 32'h7, 4'd0);
		send_item(MODE_INSERT, -5, 32'h8, 4'd0);
		// below every stored score, so rejected
		send_item(MODE_INSERT, SCORE_EMPTY, 32'h9, 4'd0);
		send_item(MODE_READ, 0, 0, 4'd15);
		send_item(MODE_READ, 0, 0, 4'd14);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 8; recv_idle_pct = 75; end
				1: begin send_idle_pct = 75; recv_idle_pct = 8; end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_req = 1'b1;
				end
			endcase
			for (int i = 0; i < 145; i++) begin
				if ($urandom_range(99) < 30)
					send_item(MODE_READ, $urandom, $urandom, $urandom_range(15));
				else
					send_item(MODE_INSERT, pick_score(), $urandom, $urandom_range(15));
			end
		end
		s_tvalid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
